[rtl/ebpf_pkg.sv]
// Package for the eBPF execute unit: word types, item kinds, status codes.
// No dependencies.
package ebpf_pkg;

  localparam logic [1:0] KIND_INSN = 2'd0;
  localparam logic [1:0] KIND_RESP = 2'd1;
  localparam logic [1:0] KIND_PRELOAD = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  op_code;
    logic [3:0]  dest_index;
    logic [3:0]  source_index;
    logic signed [15:0] displacement;
    logic signed [31:0] immediate;
    logic [31:0] immediate_high;
    logic [63:0] mem_data;
    logic        mem_ok;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] next_pc;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [1:0]  mem_size_code;
    logic [63:0] mem_store_data;
    logic [63:0] reg_value;
  } out_word_t;

endpackage

[rtl/ebpf_if.sv]
// Valid/ready stream interfaces for the eBPF execute unit.
// Depends on ebpf_pkg.
interface ebpf_in_if import ebpf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ebpf_out_if import ebpf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ebpf_cfg_if ();
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/ebpf_instruction_execute_top.sv]
// eBPF execute unit: register file, pc, sequencer and one shared
// shift/add unit for multiply and divide. Depends on ebpf_pkg, ebpf_if.
//
//  channel | dir | payload
//  in_     | in  | in_word_t (instruction, response, preload, read-back)
//  out_    | out | out_word_t, one per input word
//  cfg_    | in  | program_length
//
// Most words pass through capture, execute and result states. MUL/DIV/MOD run
// through one shift/add step per cycle in an iterate state before the result.
// Synchronous active-low reset clears registers, pc and flags.
// in_ready is low from acceptance until the result word is taken.
module ebpf_instruction_execute_top import ebpf_pkg::*; #(
  parameter int NUM_REGS = 10,
  parameter int MAX_PROGRAM = 4096
) (
  input logic clk,
  input logic rst_n,
  ebpf_in_if.sink in_ch,
  ebpf_out_if.source out_ch,
  ebpf_cfg_if.sink cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_OUT = 3'd3;
  localparam int PCW = 17;

  logic [2:0] state_r, state_nxt;
  in_word_t w_r;
  logic [63:0] rf_r [NUM_REGS];
  logic [12:0] pc_r, pc_nxt;
  logic [12:0] plen_r;
  logic [3:0] pld_r, pld_nxt;
  logic [1:0] psz_r, psz_nxt;
  logic waiting_r, waiting_nxt, halted_r, halted_nxt;
  logic store_r, store_nxt, fail_r, fail_nxt;
  out_word_t o_r, o_nxt;
  logic wr_en;
  logic [3:0] wr_idx;
  logic [63:0] wr_val;

  // iterative unit
  logic [63:0] acc_r, acc_nxt, opa_r, opa_nxt, opb_r, opb_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic mul_r, mul_nxt, wide_r, wide_nxt, mod_r, mod_nxt;

  function automatic logic [63:0] rd(input logic [63:0] rf [NUM_REGS], input logic [3:0] i);
    rd = (32'(i) < NUM_REGS) ? rf[i] : 64'd0;
  endfunction

  function automatic logic [63:0] sw16(input logic [63:0] x);
    sw16 = {48'd0, x[7:0], x[15:8]};
  endfunction
  function automatic logic [63:0] sw32(input logic [63:0] x);
    sw32 = {32'd0, x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction
  function automatic logic [63:0] sw64(input logic [63:0] x);
    sw64 = {x[7:0], x[15:8], x[23:16], x[31:24], x[39:32], x[47:40], x[55:48], x[63:56]};
  endfunction

  logic [12:0] lim;
  assign lim = (32'(plen_r) < MAX_PROGRAM) ? plen_r : 13'(MAX_PROGRAM);

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = o_r;

  logic [63:0] src, dst, kx, immx, v;
  logic [64:0] sub_t;
  logic [2:0] cls;
  logic [7:0] opn, op;
  logic [PCW-1:0] tgt;
  logic do_go, do_go_keep;
  logic [1:0] szc;
  logic [63:0] mask;
  logic [5:0] sh;

  always_comb begin
    op = w_r.op_code;
    cls = op[2:0];
    opn = {op[7:4], 4'd0};
    src = rd(rf_r, w_r.source_index);
    dst = rd(rf_r, w_r.dest_index);
    immx = {{32{w_r.immediate[31]}}, w_r.immediate};
    kx = op[3] ? src : immx;
    state_nxt = state_r;
    pc_nxt = pc_r; pld_nxt = pld_r; psz_nxt = psz_r;
    waiting_nxt = waiting_r; halted_nxt = halted_r;
    store_nxt = store_r; fail_nxt = fail_r;
    o_nxt = o_r;
    wr_en = 1'b0; wr_idx = w_r.dest_index; wr_val = 64'd0;
    acc_nxt = acc_r; opa_nxt = opa_r; opb_nxt = opb_r; cnt_nxt = cnt_r;
    mul_nxt = mul_r; wide_nxt = wide_r; mod_nxt = mod_r;
    tgt = PCW'(pc_r) + PCW'(1);
    do_go = 1'b0;
    do_go_keep = 1'b0;
    v = 64'd0;
    sub_t = 65'd0;
    szc = 2'd0;
    mask = 64'd0;
    sh = 6'd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        o_nxt = '0;
        o_nxt.reg_value = dst;
        state_nxt = S_OUT;
        unique case (w_r.item_kind)
          KIND_PRELOAD: begin
            wr_en = 1'b1; wr_val = w_r.mem_data;
            o_nxt.reg_value = (32'(w_r.dest_index) < NUM_REGS) ? w_r.mem_data : 64'd0;
          end
          KIND_READ: ;
          KIND_RESP: begin
            if (waiting_r && !halted_r) begin
              waiting_nxt = 1'b0;
              wr_idx = pld_r;
              o_nxt.reg_value = rd(rf_r, pld_r);
              if (!w_r.mem_ok) begin
                halted_nxt = 1'b1; fail_nxt = 1'b1;
              end else begin
                if (!store_r) begin
                  unique case (psz_r)
                    2'd0: mask = 64'hff;
                    2'd1: mask = 64'hffff;
                    2'd2: mask = 64'hffff_ffff;
                    default: mask = '1;
                  endcase
                  wr_en = 1'b1; wr_val = w_r.mem_data & mask;
                  if (32'(pld_r) < NUM_REGS) o_nxt.reg_value = wr_val;
                end
                do_go = 1'b1;
              end
            end
          end
          default: begin
            if (!halted_r && !waiting_r) begin
              if (pc_r >= lim) begin
                pc_nxt = lim; halted_nxt = 1'b1;
              end else if ((op & 8'he4) == 8'h60 && cls != 3'd0) begin
                unique case (op[4:3])
                  2'd0: szc = 2'd2;
                  2'd1: szc = 2'd1;
                  2'd2: szc = 2'd0;
                  default: szc = 2'd3;
                endcase
                if (cls == 3'd1) begin
                  o_nxt.mem_request = REQ_LOAD;
                  o_nxt.mem_address = src + 64'(w_r.displacement);
                end else begin
                  o_nxt.mem_request = REQ_STORE;
                  o_nxt.mem_address = dst + 64'(w_r.displacement);
                  o_nxt.mem_store_data = (cls == 3'd3) ? src : immx;
                end
                o_nxt.mem_size_code = szc;
                pld_nxt = w_r.dest_index; psz_nxt = szc;
                store_nxt = (cls != 3'd1); waiting_nxt = 1'b1;
              end else if ((op & 8'he4) == 8'h60) begin
                do_go = 1'b1;
              end else if (op == 8'h18) begin
                wr_en = 1'b1;
                wr_val = {w_r.immediate_high, w_r.immediate};
                tgt = PCW'(pc_r) + PCW'(2);
                do_go = 1'b1;
              end else if (op == 8'h05) begin
                tgt = PCW'(pc_r) + PCW'(1) + PCW'(w_r.displacement);
                do_go = 1'b1;
              end else if (op == 8'h95) begin
                halted_nxt = 1'b1;
              end else if (cls == 3'd5 && opn >= 8'h10 && opn <= 8'h70) begin
                unique case (opn)
                  8'h10: do_go_keep = (dst == kx);
                  8'h20: do_go_keep = (dst > kx);
                  8'h30: do_go_keep = (dst >= kx);
                  8'h40: do_go_keep = ((dst & kx) != 64'd0);
                  8'h50: do_go_keep = (dst != kx);
                  8'h60: do_go_keep = ($signed(dst) > $signed(kx));
                  default: do_go_keep = ($signed(dst) >= $signed(kx));
                endcase
                if (do_go_keep)
                  tgt = PCW'(pc_r) + PCW'(1) + PCW'(w_r.displacement);
                do_go = 1'b1;
              end else if (op == 8'h84) begin
                wr_en = 1'b1; wr_val = {32'd0, 32'd0 - dst[31:0]}; do_go = 1'b1;
              end else if (op == 8'h87) begin
                wr_en = 1'b1; wr_val = 64'd0 - dst; do_go = 1'b1;
              end else if (op == 8'hc7 || op == 8'hcf) begin
                wr_en = 1'b1; wr_val = 64'($signed(dst) >>> kx[5:0]); do_go = 1'b1;
              end else if (op == 8'hd4 || op == 8'hdc) begin
                do_go = 1'b1;
                if (w_r.immediate == 32'sd16) begin
                  wr_en = 1'b1; wr_val = op[3] ? sw16(dst) : {48'd0, dst[15:0]};
                end else if (w_r.immediate == 32'sd32) begin
                  wr_en = 1'b1; wr_val = op[3] ? sw32(dst) : {32'd0, dst[31:0]};
                end else if (w_r.immediate == 32'sd64) begin
                  wr_en = 1'b1; wr_val = op[3] ? sw64(dst) : dst;
                end
              end else if (cls == 3'd4 || cls == 3'd7) begin
                do_go = 1'b1;
                if (cls == 3'd4) begin
                  opa_nxt = {32'd0, dst[31:0]}; opb_nxt = {32'd0, kx[31:0]};
                end else begin
                  opa_nxt = dst; opb_nxt = kx;
                end
                sh = (cls == 3'd7) ? kx[5:0] : {1'b0, kx[4:0]};
                wr_en = 1'b1;
                unique case (opn)
                  8'h00: v = opa_nxt + opb_nxt;
                  8'h10: v = opa_nxt - opb_nxt;
                  8'h40: v = opa_nxt | opb_nxt;
                  8'h50: v = opa_nxt & opb_nxt;
                  8'h60: v = opa_nxt << sh;
                  8'h70: v = opa_nxt >> sh;
                  8'ha0: v = opa_nxt ^ opb_nxt;
                  8'hb0: v = opb_nxt;
                  8'h20, 8'h30, 8'h90: begin
                    wr_en = 1'b0; do_go = 1'b0;
                    mul_nxt = (opn == 8'h20); mod_nxt = (opn == 8'h90);
                    wide_nxt = (cls == 3'd7);
                    acc_nxt = 64'd0;
                    cnt_nxt = (cls == 3'd7) ? 7'd64 : 7'd32;
                    if (cls == 3'd4 && opn != 8'h20) opa_nxt = opa_nxt << 32;
                    state_nxt = S_ITER;
                  end
                  default: wr_en = 1'b0;
                endcase
                wr_val = (cls == 3'd7) ? v : {32'd0, v[31:0]};
              end else begin
                do_go = 1'b1;
              end
            end
          end
        endcase
        if (do_go) begin
          if (tgt[PCW-1]) begin
            halted_nxt = 1'b1; fail_nxt = 1'b1;
          end else if (tgt >= PCW'(lim)) begin
            pc_nxt = lim; halted_nxt = 1'b1;
          end else begin
            pc_nxt = tgt[12:0];
          end
        end
        if (wr_en && w_r.item_kind == KIND_INSN && 32'(w_r.dest_index) < NUM_REGS)
          o_nxt.reg_value = wr_val;
        o_nxt.status = halted_nxt ? (fail_nxt ? ST_FAIL : ST_DONE)
                                  : (waiting_nxt ? ST_WAIT : ST_RUN);
        o_nxt.next_pc = pc_nxt;
      end
      S_ITER: begin
        if (cnt_r != 7'd0) begin
          cnt_nxt = cnt_r - 7'd1;
          if (mul_r) begin
            if (opb_r[0]) acc_nxt = acc_r + opa_r;
            opb_nxt = opb_r >> 1;
            opa_nxt = opa_r << 1;
          end else begin
            // restoring divide: acc = remainder, opa shifts out dividend bits
            sub_t = {acc_r, opa_r[63]};
            opa_nxt = {opa_r[62:0], 1'b0};
            if (sub_t >= {1'b0, opb_r}) begin
              acc_nxt = sub_t[63:0] - opb_r; opa_nxt[0] = 1'b1;
            end else begin
              acc_nxt = sub_t[63:0];
            end
          end
        end else begin
          if (mul_r) v = acc_r;
          else if (opb_r == 64'd0) v = mod_r ? dst : 64'd0;
          else v = mod_r ? acc_r : opa_r;
          wr_en = 1'b1;
          wr_val = wide_r ? v : {32'd0, v[31:0]};
          if (32'(w_r.dest_index) < NUM_REGS) o_nxt.reg_value = wr_val;
          do_go = 1'b1;
          if (tgt >= PCW'(lim)) begin
            pc_nxt = lim; halted_nxt = 1'b1;
          end else begin
            pc_nxt = tgt[12:0];
          end
          o_nxt.status = halted_nxt ? ST_DONE : ST_RUN;
          o_nxt.next_pc = pc_nxt;
          state_nxt = S_OUT;
        end
      end
      default: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) w_r <= in_ch.data;
    o_r <= o_nxt;
    acc_r <= acc_nxt; opa_r <= opa_nxt; opb_r <= opb_nxt;
    cnt_r <= cnt_nxt; mul_r <= mul_nxt; wide_r <= wide_nxt; mod_r <= mod_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0; pld_r <= '0; psz_r <= '0;
      waiting_r <= 1'b0; halted_r <= 1'b0; store_r <= 1'b0; fail_r <= 1'b0;
      plen_r <= '0;
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt; pld_r <= pld_nxt; psz_r <= psz_nxt;
      waiting_r <= waiting_nxt; halted_r <= halted_nxt;
      store_r <= store_nxt; fail_r <= fail_nxt;
      if (cfg_ch.valid) plen_r <= cfg_ch.data;
      if (wr_en && 32'(wr_idx) < NUM_REGS) rf_r[wr_idx[$clog2(NUM_REGS)-1:0]] <= wr_val;
    end
  end

endmodule
